FILE: rtl/lfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN frame receiver package
// Shared types, codes and the protected identifier function.
// ----------------------------------------------------------------------------
package lfr_pkg;

  // Frame parameters
  localparam int unsigned MAX_DATA   = 8;
  localparam logic [7:0]  SYNC_BYTE  = 8'h55;
  localparam logic [7:0]  SYNC_TRIES = 8'd254;
  localparam logic [5:0]  ID_MASK    = 6'h3F;

  // Event codes (s_axis_tuser)
  localparam logic [1:0] FUNC_BREAK  = 2'd0;
  localparam logic [1:0] FUNC_BYTE   = 2'd1;
  localparam logic [1:0] FUNC_HEADER = 2'd2;

  // Result status codes (m_axis_tuser)
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_HEADER   = 2'd1;
  localparam logic [1:0] ST_PARITY   = 2'd2;
  localparam logic [1:0] ST_CHECKSUM = 2'd3;

  // Register indexes
  localparam logic REG_ENHANCED    = 1'b0;
  localparam logic REG_DATA_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC,
    PH_PID,
    PH_DATA
  } phase_t;

  // Protected identifier: id with P0 in bit 6, P1 in bit 7
  function automatic logic [7:0] make_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

endpackage

FILE: rtl/lin_frame_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN frame receiver
// Sync search, PID parity check, data collection and checksum check.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one bus event per transaction: tuser selects break,
//   received byte or header sent; tdata carries the byte and the header id.
//   Master stream carries one result per finished frame, per parity error
//   and per header sent; tuser holds the status code.
//   APB port: register 0 (addr 0x0) enhanced checksum enable, register 1
//   (addr 0x4) data length, 1..8 (0 acts as 1, above 8 acts as 8).
// Timing:
//   An event is captured in the input register, evaluated against the frame
//   state once the output register can take a value, and its result lands in
//   the output register.
//   One event per cycle sustained; the only limit is the output register.
// Reset: frame state returns to idle, registers to classic checksum and
//   eight data bytes; both stream sides come up empty.
// Stall: with the result held by m_axis_tready low, the event in the input
//   register waits and s_axis_tready drops once that register is occupied.
// ----------------------------------------------------------------------------
module lin_frame_receiver_top (
  input  logic         clk,
  input  logic         rst,
  // Event stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // [7:0] byte_value, [13:8] frame_id, [15:14] zero
  input  logic [1:0]   s_axis_tuser,   // [1:0] func
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata,   // [0] sync_error, [6:1] out_id,
                                       // [14:7] protected_id, [78:15] payload,
                                       // [82:79] payload_length, [87:83] zero
  output logic [1:0]   m_axis_tuser,   // [1:0] status
  // APB configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import lfr_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic       enhanced_checksum;
  logic [3:0] data_length;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enhanced_checksum <= 1'b0;
      data_length       <= 4'(MAX_DATA);
    end else if (cfg_write) begin
      case (paddr[2])
        REG_ENHANCED:    enhanced_checksum <= pwdata[0];
        REG_DATA_LENGTH: data_length       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ENHANCED:    prdata = {31'd0, enhanced_checksum};
      REG_DATA_LENGTH: prdata = {28'd0, data_length};
      default:         prdata = 32'd0;
    endcase
  end

  // Effective data length, clamped to 1..MAX_DATA
  logic [3:0] dlen;
  always_comb begin
    if (data_length == 4'd0)                 dlen = 4'd1;
    else if (data_length > 4'(MAX_DATA))     dlen = 4'(MAX_DATA);
    else                                     dlen = data_length;
  end

  // --------------------------------------------------------------------------
  // Pipeline control: input register -> evaluate -> output register
  // --------------------------------------------------------------------------
  logic       in_valid;
  logic [1:0] in_func;
  logic [7:0] in_byte;
  logic [5:0] in_fid;
  logic       advance;   // output register can take a new value this cycle
  logic       proc;      // event in input register is evaluated this cycle

  assign advance       = ~m_axis_tvalid | m_axis_tready;
  assign proc          = in_valid & advance;
  assign s_axis_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func <= s_axis_tuser;
      in_byte <= s_axis_tdata[7:0];
      in_fid  <= s_axis_tdata[13:8];
    end
  end

  // --------------------------------------------------------------------------
  // Frame state
  // --------------------------------------------------------------------------
  phase_t      phase, phase_next;
  logic [7:0]  zero_run, zero_run_next;
  logic        sync_flag, sync_flag_next;
  logic [5:0]  current_id, current_id_next;
  logic [7:0]  current_pid, current_pid_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [11:0] running_sum, running_sum_next;
  logic [7:0]  payload_store [MAX_DATA];
  logic        store_we;

  // Result of the evaluated event
  logic        res_valid;
  logic [1:0]  res_status;
  logic        res_sync_error;
  logic [5:0]  res_id;
  logic [7:0]  res_pid;
  logic [63:0] res_payload;
  logic [3:0]  res_length;

  // Checksum and payload packing
  logic [7:0]  zero_run_inc;
  logic [7:0]  byte_pid;
  logic [11:0] sum_total;
  logic [8:0]  fold1;
  logic [8:0]  fold2;
  logic [7:0]  expect_cs;
  logic [63:0] packed_payload;

  assign zero_run_inc = zero_run + 8'd1;
  assign byte_pid     = make_pid(in_byte[5:0] & ID_MASK);
  assign sum_total    = running_sum + (enhanced_checksum ? {4'd0, current_pid} : 12'd0);
  assign fold1        = {1'b0, sum_total[7:0]} + {5'd0, sum_total[11:8]};
  assign fold2        = {1'b0, fold1[7:0]} + {8'd0, fold1[8]};
  assign expect_cs    = ~fold2[7:0];

  always_comb begin
    for (int i = 0; i < MAX_DATA; i++) begin
      packed_payload[8*i +: 8] = (4'(i) < byte_count) ? payload_store[i] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      zero_run    <= 8'd0;
      sync_flag   <= 1'b0;
      current_id  <= 6'd0;
      current_pid <= 8'd0;
      byte_count  <= 4'd0;
      running_sum <= 12'd0;
    end else if (proc) begin
      phase       <= phase_next;
      zero_run    <= zero_run_next;
      sync_flag   <= sync_flag_next;
      current_id  <= current_id_next;
      current_pid <= current_pid_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && store_we) begin
      payload_store[byte_count[2:0]] <= in_byte;
    end
  end

  always_comb begin
    phase_next       = phase;
    zero_run_next    = zero_run;
    sync_flag_next   = sync_flag;
    current_id_next  = current_id;
    current_pid_next = current_pid;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    store_we         = 1'b0;
    res_valid        = 1'b0;
    res_status       = ST_OK;
    res_sync_error   = 1'b0;
    res_id           = current_id;
    res_pid          = current_pid;
    res_payload      = 64'd0;
    res_length       = dlen;

    case (in_func)
      FUNC_BREAK: begin
        phase_next       = PH_SYNC;
        zero_run_next    = 8'd0;
        sync_flag_next   = 1'b0;
        byte_count_next  = 4'd0;
        running_sum_next = 12'd0;
      end
      FUNC_HEADER: begin
        current_id_next  = in_fid;
        current_pid_next = make_pid(in_fid);
        phase_next       = PH_DATA;
        sync_flag_next   = 1'b0;
        byte_count_next  = 4'd0;
        running_sum_next = 12'd0;
        res_valid        = 1'b1;
        res_status       = ST_HEADER;
        res_id           = in_fid;
        res_pid          = make_pid(in_fid);
      end
      FUNC_BYTE: begin
        case (phase)
          PH_SYNC: begin
            if (in_byte == SYNC_BYTE) begin
              phase_next = PH_PID;
            end else if (in_byte != 8'd0) begin
              sync_flag_next = 1'b1;
              phase_next     = PH_PID;
            end else begin
              zero_run_next = zero_run_inc;
              if (zero_run_inc >= SYNC_TRIES) phase_next = PH_PID;
            end
          end
          PH_PID: begin
            if (byte_pid != in_byte) begin
              phase_next     = PH_IDLE;
              res_valid      = 1'b1;
              res_status     = ST_PARITY;
              res_sync_error = sync_flag;
              res_id         = in_byte[5:0];
              res_pid        = in_byte;
            end else begin
              current_id_next  = in_byte[5:0];
              current_pid_next = in_byte;
              phase_next       = PH_DATA;
              byte_count_next  = 4'd0;
              running_sum_next = 12'd0;
            end
          end
          PH_DATA: begin
            if (byte_count < dlen) begin
              store_we         = 1'b1;
              byte_count_next  = byte_count + 4'd1;
              running_sum_next = running_sum + {4'd0, in_byte};
            end else begin
              phase_next  = PH_IDLE;
              res_valid   = 1'b1;
              res_payload = packed_payload;
              res_length  = byte_count;
              if (in_byte == expect_cs) begin
                res_status = ST_OK;
              end else begin
                res_status     = ST_CHECKSUM;
                res_sync_error = sync_flag;
              end
            end
          end
          default: ;  // idle: byte ignored
        endcase
      end
      default: ;  // unused event code
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [1:0]  out_status;
  logic        out_sync_error;
  logic [5:0]  out_id;
  logic [7:0]  out_pid;
  logic [63:0] out_payload;
  logic [3:0]  out_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= proc & res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      out_status     <= res_status;
      out_sync_error <= res_sync_error;
      out_id         <= res_id;
      out_pid        <= res_pid;
      out_payload    <= res_payload;
      out_length     <= res_length;
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {5'd0, out_length, out_payload, out_pid, out_id, out_sync_error};

endmodule
